// ===== design/kcpc_pkg.sv =====
`timescale 1ns / 1ps

package kcpc_pkg;

    localparam int KEY_W           = 4;
    localparam int CHORD_TABLE_LEN = 8;
    localparam int DEF_NUM_CHORDS  = 8;
    localparam int CHORD_W         = 3;
    localparam int HOLD_W          = 16;
    localparam int STAB_W          = 8;
    localparam int CLICK_CNT_W     = 8;
    localparam int ELAPSED_W       = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int DEB_W    = 8;
    localparam int LONG_W   = 16;
    localparam int IDLE_W   = 24;
    localparam int WINDOW_W = 16;
    localparam int CLICKS_W = 8;

    localparam logic [DEB_W-1:0]    DEF_DEBOUNCE = 8'd3;
    localparam logic [LONG_W-1:0]   DEF_LONG     = 16'd100;
    localparam logic [IDLE_W-1:0]   DEF_IDLE     = 24'd1500;
    localparam logic [WINDOW_W-1:0] DEF_WINDOW   = 16'd50;
    localparam logic [CLICKS_W-1:0] DEF_CLICKS   = 8'd8;

    localparam logic [KEY_W-1:0] KEY_BUTTON_1 = 4'h1;
    localparam logic [KEY_W-1:0] KEY_BUTTON_2 = 4'h2;
    localparam logic [KEY_W-1:0] KEY_BUTTON_3 = 4'h4;
    localparam logic [KEY_W-1:0] KEY_BUTTON_4 = 4'h8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE = 3'd0,
        CFG_LONG     = 3'd1,
        CFG_IDLE     = 3'd2,
        CFG_WINDOW   = 3'd3,
        CFG_CLICKS   = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        EVT_NONE  = 2'd0,
        EVT_SHORT = 2'd1,
        EVT_LONG  = 2'd2
    } t_event_kind;

    typedef enum logic [1:0] {
        ACT_NONE      = 2'd0,
        ACT_SELF_TEST = 2'd1,
        ACT_MENU      = 2'd2,
        ACT_FACTORY   = 2'd3
    } t_action;

    // Result of the chord bank for one evaluated tick.
    typedef struct packed {
        t_event_kind        kind;
        logic [CHORD_W-1:0] chord;
        logic               active;
        logic               click_req;
        logic [KEY_W-1:0]   click_key;
    } t_chord_evt;

    function automatic logic [KEY_W-1:0] chord_value(input logic [CHORD_W-1:0] idx);
        logic [KEY_W-1:0] v;
        unique case (idx)
            3'd0:    v = KEY_BUTTON_1;
            3'd1:    v = KEY_BUTTON_2;
            3'd2:    v = KEY_BUTTON_3;
            3'd3:    v = KEY_BUTTON_4;
            3'd4:    v = KEY_BUTTON_1 | KEY_BUTTON_2;
            3'd5:    v = KEY_BUTTON_1 | KEY_BUTTON_3;
            3'd6:    v = KEY_BUTTON_2 | KEY_BUTTON_3;
            default: v = KEY_BUTTON_2 | KEY_BUTTON_4;
        endcase
        return v;
    endfunction

endpackage

// ===== design/kcpc_debounce.sv =====
`timescale 1ns / 1ps

module kcpc_debounce (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_advance,
    input  logic [kcpc_pkg::KEY_W-1:0]       i_raw_keys,
    input  logic [kcpc_pkg::DEB_W-1:0]       i_debounce_ticks,
    output logic                             o_eval
);

    logic [kcpc_pkg::KEY_W-1:0]  r_stable;
    logic [kcpc_pkg::STAB_W-1:0] r_count;
    logic [kcpc_pkg::STAB_W-1:0] n_count;
    logic                        w_same;

    always_comb begin
        w_same  = (i_raw_keys == r_stable);
        n_count = (&r_count) ? r_count : r_count + 1'b1;
        o_eval  = w_same && (n_count >= i_debounce_ticks);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= '0;
            r_count  <= '0;
        end else if (i_advance) begin
            if (!w_same) begin
                r_stable <= i_raw_keys;
                r_count  <= '0;
            end else begin
                r_count <= n_count;
            end
        end
    end

endmodule

// ===== design/kcpc_chord_bank.sv =====
`timescale 1ns / 1ps

module kcpc_chord_bank #(
    parameter int NUM_CHORDS = kcpc_pkg::DEF_NUM_CHORDS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  logic                          i_eval,
    input  logic [kcpc_pkg::KEY_W-1:0]    i_keys,
    input  logic                          i_power_off,
    input  logic [kcpc_pkg::LONG_W-1:0]   i_long_ticks,
    output kcpc_pkg::t_chord_evt          o_evt
);

    localparam int SPAN = (NUM_CHORDS < kcpc_pkg::CHORD_TABLE_LEN) ?
                          NUM_CHORDS : kcpc_pkg::CHORD_TABLE_LEN;

    logic [kcpc_pkg::HOLD_W-1:0] r_hold [SPAN];
    logic [kcpc_pkg::HOLD_W-1:0] n_hold [SPAN];
    logic [kcpc_pkg::KEY_W-1:0]  r_prev;

    always_comb begin
        logic [kcpc_pkg::KEY_W-1:0]  c;
        logic [kcpc_pkg::HOLD_W-1:0] h;
        o_evt = '{kind: kcpc_pkg::EVT_NONE, chord: '0, active: 1'b0,
                  click_req: 1'b0, click_key: '0};
        for (int i = 0; i < SPAN; i++) begin
            c = kcpc_pkg::chord_value(kcpc_pkg::CHORD_W'(i));
            h = r_hold[i];
            if (i_keys == c) begin
                o_evt.active = 1'b1;
                if (!(&h)) begin
                    h = h + 1'b1;
                    if (h == i_long_ticks) begin
                        o_evt.kind  = kcpc_pkg::EVT_LONG;
                        o_evt.chord = kcpc_pkg::CHORD_W'(i);
                        // Single keys 1 and 2 back off so the long event repeats.
                        if (c == kcpc_pkg::KEY_BUTTON_1 || c == kcpc_pkg::KEY_BUTTON_2) begin
                            h = h - 1'b1;
                        end
                    end
                end
            end else if (i_keys == '0 && r_prev == c) begin
                if (h < i_long_ticks) begin
                    o_evt.kind      = kcpc_pkg::EVT_SHORT;
                    o_evt.chord     = kcpc_pkg::CHORD_W'(i);
                    o_evt.click_req = i_power_off;
                    o_evt.click_key = c;
                    h = '0;
                end
            end else begin
                h = '0;
            end
            n_hold[i] = h;
        end
        if (!i_eval) begin
            o_evt = '{kind: kcpc_pkg::EVT_NONE, chord: '0, active: 1'b0,
                      click_req: 1'b0, click_key: '0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            for (int i = 0; i < SPAN; i++) begin
                r_hold[i] <= '0;
            end
        end else if (i_advance && i_eval) begin
            r_prev <= i_keys;
            for (int i = 0; i < SPAN; i++) begin
                r_hold[i] <= n_hold[i];
            end
        end
    end

endmodule

// ===== design/kcpc_click.sv =====
`timescale 1ns / 1ps

// Tick differences are kept as elapsed counters, which wrap the same way the
// differences of a free-running timer do.
module kcpc_click (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_advance,
    input  logic                             i_eval,
    input  kcpc_pkg::t_chord_evt             i_evt,
    input  logic [kcpc_pkg::IDLE_W-1:0]      i_idle_ticks,
    input  logic [kcpc_pkg::WINDOW_W-1:0]    i_window_ticks,
    input  logic [kcpc_pkg::CLICKS_W-1:0]    i_clicks_needed,
    output kcpc_pkg::t_action                o_action,
    output logic                             o_dimmed
);

    logic [kcpc_pkg::ELAPSED_W-1:0]   r_idle_el;
    logic [kcpc_pkg::ELAPSED_W-1:0]   n_idle_el;
    logic [kcpc_pkg::ELAPSED_W-1:0]   r_click_el;
    logic [kcpc_pkg::ELAPSED_W-1:0]   w_click_inc;
    logic [kcpc_pkg::ELAPSED_W-1:0]   n_click_el;
    logic [kcpc_pkg::KEY_W-1:0]       r_click_key;
    logic [kcpc_pkg::CLICK_CNT_W-1:0] r_click_cnt;
    logic [kcpc_pkg::CLICK_CNT_W-1:0] w_cnt_eff;
    logic                             w_differ;
    logic                             w_in_win;

    always_comb begin
        w_click_inc = r_click_el + 1'b1;
        w_differ    = (r_click_key != i_evt.click_key);
        n_click_el  = w_differ ? '0 : w_click_inc;
        w_in_win    = n_click_el <= kcpc_pkg::ELAPSED_W'(i_window_ticks);
        w_cnt_eff   = (w_differ || !w_in_win) ? kcpc_pkg::CLICK_CNT_W'(1) : r_click_cnt;

        o_action = kcpc_pkg::ACT_NONE;
        if (i_evt.click_req && w_in_win && w_cnt_eff >= i_clicks_needed) begin
            priority if (i_evt.click_key == kcpc_pkg::KEY_BUTTON_1) begin
                o_action = kcpc_pkg::ACT_SELF_TEST;
            end else if (i_evt.click_key == kcpc_pkg::KEY_BUTTON_2) begin
                o_action = kcpc_pkg::ACT_MENU;
            end else if (i_evt.click_key == kcpc_pkg::KEY_BUTTON_3) begin
                o_action = kcpc_pkg::ACT_FACTORY;
            end else begin
                o_action = kcpc_pkg::ACT_NONE;
            end
        end

        // An evaluated tick advances the timer before the idle test.
        n_idle_el = i_eval ? r_idle_el + 1'b1 : r_idle_el;
        o_dimmed  = (n_idle_el > kcpc_pkg::ELAPSED_W'(i_idle_ticks)) && !i_evt.active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_el   <= '0;
            r_click_el  <= '0;
            r_click_key <= '0;
            r_click_cnt <= '0;
        end else if (i_advance && i_eval) begin
            r_idle_el <= i_evt.active ? '0 : n_idle_el;
            if (i_evt.click_req) begin
                r_click_key <= i_evt.click_key;
                r_click_cnt <= (&w_cnt_eff) ? w_cnt_eff : w_cnt_eff + 1'b1;
                r_click_el  <= w_in_win ? n_click_el : '0;
            end else begin
                r_click_el <= w_click_inc;
            end
        end
    end

endmodule

// ===== design/key_chord_press_classifier.sv =====
`timescale 1ns / 1ps

// An accepted item is held in the input register and its result in the output register.
// Throughput: one item per cycle while the result side is ready. A stalled result
// holds the input register, so one more item is taken and then s_axis_tready drops.
// Reset (synchronous, active low) clears debounce, hold, click and idle state
// and loads the default register values.
module key_chord_press_classifier #(
    parameter int NUM_CHORDS = kcpc_pkg::DEF_NUM_CHORDS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [kcpc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [kcpc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [3:0] raw_keys, [4] power_off
    input  logic [7:0]                          s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [1:0] event_kind, [4:2] chord_index, [5] key_active, [6] dimmed,
    // [8:7] special_action
    output logic [15:0]                         m_axis_tdata
);

    logic [kcpc_pkg::DEB_W-1:0]    r_debounce;
    logic [kcpc_pkg::LONG_W-1:0]   r_long;
    logic [kcpc_pkg::IDLE_W-1:0]   r_idle;
    logic [kcpc_pkg::WINDOW_W-1:0] r_window;
    logic [kcpc_pkg::CLICKS_W-1:0] r_clicks;

    logic                          r_in_valid;
    logic [kcpc_pkg::KEY_W-1:0]    r_raw;
    logic                          r_off;
    logic                          r_out_valid;
    logic [8:0]                    r_result;

    logic                          w_advance;
    logic                          w_eval;
    kcpc_pkg::t_chord_evt          w_evt;
    kcpc_pkg::t_action             w_action;
    logic                          w_dimmed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= kcpc_pkg::DEF_DEBOUNCE;
            r_long     <= kcpc_pkg::DEF_LONG;
            r_idle     <= kcpc_pkg::DEF_IDLE;
            r_window   <= kcpc_pkg::DEF_WINDOW;
            r_clicks   <= kcpc_pkg::DEF_CLICKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                kcpc_pkg::CFG_DEBOUNCE: r_debounce <= i_cfg_wdata[kcpc_pkg::DEB_W-1:0];
                kcpc_pkg::CFG_LONG:     r_long     <= i_cfg_wdata[kcpc_pkg::LONG_W-1:0];
                kcpc_pkg::CFG_IDLE:     r_idle     <= i_cfg_wdata[kcpc_pkg::IDLE_W-1:0];
                kcpc_pkg::CFG_WINDOW:   r_window   <= i_cfg_wdata[kcpc_pkg::WINDOW_W-1:0];
                kcpc_pkg::CFG_CLICKS:   r_clicks   <= i_cfg_wdata[kcpc_pkg::CLICKS_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_result};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_raw <= s_axis_tdata[kcpc_pkg::KEY_W-1:0];
            r_off <= s_axis_tdata[kcpc_pkg::KEY_W];
        end
        if (w_advance) begin
            r_result <= {w_action, w_dimmed, w_evt.active, w_evt.chord, w_evt.kind};
        end
    end

    kcpc_debounce u_debounce (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (w_advance),
        .i_raw_keys       (r_raw),
        .i_debounce_ticks (r_debounce),
        .o_eval           (w_eval)
    );

    kcpc_chord_bank #(
        .NUM_CHORDS (NUM_CHORDS)
    ) u_chord_bank (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (w_advance),
        .i_eval       (w_eval),
        .i_keys       (r_raw),
        .i_power_off  (r_off),
        .i_long_ticks (r_long),
        .o_evt        (w_evt)
    );

    kcpc_click u_click (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (w_advance),
        .i_eval          (w_eval),
        .i_evt           (w_evt),
        .i_idle_ticks    (r_idle),
        .i_window_ticks  (r_window),
        .i_clicks_needed (r_clicks),
        .o_action        (w_action),
        .o_dimmed        (w_dimmed)
    );

endmodule

// ===== design/kcpc_checker.sv =====
`timescale 1ns / 1ps

module kcpc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // A stalled result keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A held chord clears the dim flag.
    a_dim_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[5] && m_axis_tdata[6]))
        else $error("dimmed while a chord is held");

    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("undefined event kind");

    a_chord_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == 2'd0 |-> m_axis_tdata[4:2] == 3'd0)
        else $error("chord index without an event");

    // Special actions come only from clicks, which are short presses.
    a_action_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[8:7] != 2'd0 |-> m_axis_tdata[1:0] == 2'd1)
        else $error("special action without a short press");

endmodule

bind key_chord_press_classifier kcpc_checker u_kcpc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
